/* sv/rpn_pkg.sv */
package rpn_pkg;

  localparam int unsigned DataW = 32;

  // Token kinds
  localparam logic [2:0] OP_NUM = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [DataW-1:0] number;
    logic                    last_token;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] answer;
    logic [1:0]              status;
  } rsp_t;

endpackage

/* sv/rpn_stack_evaluator_top.sv */
// Postfix integer expression evaluator, one token per request.
// Request channel: drive req_i and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy stays high while a
// token is being worked on.
// Result channel: on a token marked last_token, result_valid_o is high for
// exactly one cycle, with the answer and status on result_o. The receiver
// cannot stall; the result must be captured in that cycle.
// Operands live in a single-port-write, registered-read stack memory, so
// an operator on two or more entries reads them in turn, top entry first.
// Per token: a number is pushed; add/subtract/multiply read both operands,
//   execute and write back; divide adds a one-quotient-bit-per-cycle
//   restoring divider and a sign step; underflow or overflow only latch
//   the error; divide by zero reads both operands, then latches the error.
//   A last token adds one stack read for the top entry, or none on an
//   empty stack; the result strobe comes in the cycle busy drops.
// Reset clears the stack count, the error latch and the result strobe; the
// stack memory itself is not cleared, since only written entries are read.
module rpn_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rpn_pkg::req_t req_i,
  output logic          result_valid_o,
  output rpn_pkg::rsp_t result_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = rpn_pkg::DataW;
  localparam int unsigned SW = $clog2(DW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_EXEC,
    S_DIV,
    S_DIV_SGN,
    S_WB,
    S_FIN_RD,
    S_FIN_OUT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic [1:0]      err_q;
  logic [2:0]      op_q;
  logic            last_q;
  logic [DW-1:0]   a_q;
  logic [DW-1:0]   rd_q;
  logic [DW-1:0]   res_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   quo_q;
  logic [DW-1:0]   dvs_q;
  logic            neg_q;
  logic [SW-1:0]   step_q;
  logic            res_valid_q;
  rpn_pkg::rsp_t   rsp_q;

  logic [DW-1:0]   stack_mem_q [STACK_DEPTH];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [DW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;

  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   cnt_m2;
  logic            accept;
  logic            stack_full;
  logic [2*DW-1:0] prod;
  logic [DW:0]     rem_sh;
  logic [DW:0]     diff;
  logic [DW-1:0]   mag_b;
  logic [DW-1:0]   mag_a;

  assign cnt_m1     = count_q - CW'(1);
  assign cnt_m2     = count_q - CW'(2);
  assign accept     = start && (state_q == S_IDLE);
  assign stack_full = (count_q >= CW'(STACK_DEPTH));
  assign busy       = (state_q != S_IDLE);

  // Operand arithmetic: b is the older entry in rd_q, a the top in a_q
  assign prod   = rd_q * a_q;
  assign mag_b  = rd_q[DW-1] ? (DW'(0) - rd_q) : rd_q;
  assign mag_a  = a_q[DW-1] ? (DW'(0) - a_q) : a_q;
  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  // Select memory read and write ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = req_i.number;
    mem_raddr = cnt_m1[AW-1:0];
    if (accept && (req_i.op == rpn_pkg::OP_NUM) && !stack_full) begin
      mem_we = 1'b1;
    end
    if (state_q == S_WB) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_m2[AW-1:0];
      mem_wdata = res_q;
    end
    if (state_q == S_RD_B) begin
      mem_raddr = cnt_m2[AW-1:0];
    end
  end

  // Stack memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= stack_mem_q[mem_raddr];
  end

  // Sequence tokens: push, operand reads, execute, write back, final result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= rpn_pkg::ST_OK;
      op_q        <= rpn_pkg::OP_NUM;
      last_q      <= 1'b0;
      a_q         <= '0;
      res_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      dvs_q       <= '0;
      neg_q       <= 1'b0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q   <= req_i.op;
            last_q <= req_i.last_token;
            state_q <= req_i.last_token ? S_FIN_RD : S_IDLE;
            case (req_i.op) inside
              rpn_pkg::OP_NUM: begin
                if (stack_full) begin
                  if (err_q == rpn_pkg::ST_OK) err_q <= rpn_pkg::ST_OVER;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
                if (count_q < CW'(2)) begin
                  if (err_q == rpn_pkg::ST_OK) err_q <= rpn_pkg::ST_UNDER;
                end else begin
                  state_q <= S_RD_A;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD_A: begin
          state_q <= S_RD_B;
        end
        S_RD_B: begin
          // Top entry arrives now; the next one follows
          a_q     <= rd_q;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_WB;
          case (op_q)
            rpn_pkg::OP_ADD: res_q <= rd_q + a_q;
            rpn_pkg::OP_SUB: res_q <= rd_q - a_q;
            rpn_pkg::OP_MUL: res_q <= prod[DW-1:0];
            default: begin
              if (a_q == '0) begin
                if (err_q == rpn_pkg::ST_OK) err_q <= rpn_pkg::ST_DIVZ;
                state_q <= last_q ? S_FIN_RD : S_IDLE;
              end else begin
                rem_q   <= '0;
                quo_q   <= mag_b;
                dvs_q   <= mag_a;
                neg_q   <= rd_q[DW-1] ^ a_q[DW-1];
                step_q  <= '0;
                state_q <= S_DIV;
              end
            end
          endcase
        end
        S_DIV: begin
          // One restoring quotient bit per cycle
          if (!diff[DW]) begin
            rem_q <= diff[DW-1:0];
            quo_q <= {quo_q[DW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[DW-1:0];
            quo_q <= {quo_q[DW-2:0], 1'b0};
          end
          step_q <= step_q + SW'(1);
          if (step_q == SW'(DW - 1)) begin
            state_q <= S_DIV_SGN;
          end
        end
        S_DIV_SGN: begin
          res_q   <= neg_q ? (DW'(0) - quo_q) : quo_q;
          state_q <= S_WB;
        end
        S_WB: begin
          count_q <= cnt_m1;
          state_q <= last_q ? S_FIN_RD : S_IDLE;
        end
        S_FIN_RD: begin
          if (count_q == '0) begin
            res_valid_q   <= 1'b1;
            rsp_q.answer  <= '0;
            rsp_q.status  <= (err_q != rpn_pkg::ST_OK) ? err_q : rpn_pkg::ST_UNDER;
            count_q       <= '0;
            err_q         <= rpn_pkg::ST_OK;
            state_q       <= S_IDLE;
          end else begin
            state_q <= S_FIN_OUT;
          end
        end
        S_FIN_OUT: begin
          // Emit top entry and clear the expression state
          res_valid_q  <= 1'b1;
          rsp_q.answer <= rd_q;
          rsp_q.status <= err_q;
          count_q      <= '0;
          err_q        <= rpn_pkg::ST_OK;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = rsp_q;

endmodule
